// ----- hdl/swept_box_collision_unit_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef SWEPT_BOX_COLLISION_UNIT_ASSERT_SVH
`define SWEPT_BOX_COLLISION_UNIT_ASSERT_SVH

// Check an implication every clock outside reset.
`define SBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle.
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sbc_pkg.sv -----
package sbc_pkg;

  localparam int CoordWidth = 24;
  localparam int FracBits   = 8;
  localparam int SizeWidth  = 12;
  localparam int VelWidth   = 16;
  localparam int OutFrac    = 16;
  localparam int FracWidth  = 24;

  // edge differences and the shifted numerator
  localparam int DiffWidth  = CoordWidth + 2;
  localparam int NumWidth   = DiffWidth + OutFrac;
  // divider: one quotient bit per cell
  localparam int QuoWidth   = NumWidth;
  localparam int RemWidth   = VelWidth + 1;
  localparam int DivCells   = QuoWidth;

  typedef enum logic [2:0] {
    SIDE_RIGHT = 3'd0,
    SIDE_DOWN  = 3'd1,
    SIDE_LEFT  = 3'd2,
    SIDE_UP    = 3'd3,
    SIDE_NONE  = 3'd4
  } side_e;

  typedef struct packed {
    logic [CoordWidth-1:0] self_left;
    logic [CoordWidth-1:0] self_top;
    logic [SizeWidth-1:0]  self_width;
    logic [SizeWidth-1:0]  self_height;
    logic [VelWidth-1:0]   vel_x;
    logic [VelWidth-1:0]   vel_y;
    logic [CoordWidth-1:0] other_left;
    logic [CoordWidth-1:0] other_top;
    logic [SizeWidth-1:0]  other_width;
    logic [SizeWidth-1:0]  other_height;
  } req_t;

  typedef struct packed {
    logic                 overlap;
    logic [2:0]           hit_side;
    logic [FracWidth-1:0] contact_fraction;
    logic                 fraction_saturated;
  } rsp_t;

  // item flowing down the divider chain
  typedef struct packed {
    logic                valid;
    logic                overlap;
    side_e               side;
    logic                neg;
    logic [QuoWidth-1:0] dividend;
    logic [RemWidth-1:0] divisor;
    logic [RemWidth-1:0] rem;
    logic [QuoWidth-1:0] quo;
  } cell_t;

endpackage

// ----- hdl/sbc_if.sv -----
interface sbc_req_if;
  import sbc_pkg::*;
  logic valid;
  logic ready;
  req_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

interface sbc_rsp_if;
  import sbc_pkg::*;
  logic valid;
  logic ready;
  rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

// ----- hdl/sbc_front.sv -----
module sbc_front
  import sbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  req_t  req_i,
  output cell_t cell_o
);

  localparam int ProdWidth = DiffWidth + VelWidth;

  logic signed [DiffWidth-1:0] sl, st, sw, sh, ol, ot, ow, oh, vx, vy;
  logic signed [DiffWidth-1:0] dxr, dyb, dxl, dyt;
  logic signed [DiffWidth-1:0] ml, mt;
  logic ov;

  // stage 1 registers
  logic                        v1_q;
  logic                        ov_q;
  logic signed [DiffWidth-1:0] dxr_q, dyb_q, dxl_q, dyt_q;
  logic signed [VelWidth-1:0]  vx_q, vy_q;
  logic signed [ProdWidth-1:0] p0_q, p1_q, p2_q, p3_q;

  always_comb begin
    sl = DiffWidth'($signed(req_i.self_left));
    st = DiffWidth'($signed(req_i.self_top));
    ol = DiffWidth'($signed(req_i.other_left));
    ot = DiffWidth'($signed(req_i.other_top));
    sw = DiffWidth'({req_i.self_width, {FracBits{1'b0}}});
    sh = DiffWidth'({req_i.self_height, {FracBits{1'b0}}});
    ow = DiffWidth'({req_i.other_width, {FracBits{1'b0}}});
    oh = DiffWidth'({req_i.other_height, {FracBits{1'b0}}});
    vx = DiffWidth'($signed(req_i.vel_x));
    vy = DiffWidth'($signed(req_i.vel_y));
    dxr = ol - (sl + sw);
    dyb = ot - (st + sh);
    dxl = (ol + ow) - sl;
    dyt = (ot + oh) - st;
    ml = sl + vx;
    mt = st + vy;
    ov = (ol < ml + sw) && (ml < ol + ow) && (ot < mt + sh) && (mt < ot + oh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ov_q  <= ov;
      dxr_q <= dxr;
      dyb_q <= dyb;
      dxl_q <= dxl;
      dyt_q <= dyt;
      vx_q  <= $signed(req_i.vel_x);
      vy_q  <= $signed(req_i.vel_y);
      p0_q  <= ProdWidth'(dxr * vy);
      p1_q  <= ProdWidth'(dyb * vx);
      p2_q  <= ProdWidth'(dxl * vy);
      p3_q  <= ProdWidth'(dyt * vx);
    end
  end

  logic signed [ProdWidth:0] cr_dr, cr_dl, cr_ul;
  logic signed [ProdWidth:0] cr_ur;
  side_e side;
  logic signed [DiffWidth-1:0] num;
  logic signed [VelWidth-1:0]  den;
  logic signed [NumWidth-1:0]  numx;
  logic                        nneg, dneg;

  always_comb begin
    cr_dr = (ProdWidth+1)'(p0_q) - (ProdWidth+1)'(p1_q);
    cr_dl = (ProdWidth+1)'(p2_q) - (ProdWidth+1)'(p1_q);
    cr_ul = (ProdWidth+1)'(p2_q) - (ProdWidth+1)'(p3_q);
    cr_ur = (ProdWidth+1)'(p0_q) - (ProdWidth+1)'(p3_q);
    if (vx_q > 0 && vy_q > 0) begin
      side = (cr_dr < 0) ? SIDE_DOWN : SIDE_RIGHT;
    end else if (vx_q < 0 && vy_q > 0) begin
      side = (cr_dl < 0) ? SIDE_LEFT : SIDE_DOWN;
    end else if (vx_q < 0 && vy_q < 0) begin
      side = (cr_ul < 0) ? SIDE_UP : ((cr_ul == 0) ? SIDE_NONE : SIDE_LEFT);
    end else if (vx_q > 0 && vy_q < 0) begin
      side = (cr_ur <= 0) ? SIDE_RIGHT : SIDE_UP;
    end else if (vx_q > 0) begin
      side = SIDE_RIGHT;
    end else if (vy_q > 0) begin
      side = SIDE_DOWN;
    end else if (vx_q < 0) begin
      side = SIDE_LEFT;
    end else if (vy_q < 0) begin
      side = SIDE_UP;
    end else begin
      side = SIDE_NONE;
    end
    unique case (side)
      SIDE_RIGHT: begin num = dxr_q; den = vx_q; end
      SIDE_DOWN:  begin num = dyb_q; den = vy_q; end
      SIDE_LEFT:  begin num = dxl_q; den = vx_q; end
      SIDE_UP:    begin num = dyt_q; den = vy_q; end
      default:    begin num = '0;    den = VelWidth'(1); end
    endcase
    nneg = num[DiffWidth-1];
    dneg = den[VelWidth-1];
    numx = {num, {OutFrac{1'b0}}};
    cell_o.valid    = v1_q;
    cell_o.overlap  = ov_q;
    cell_o.side     = side;
    cell_o.neg      = nneg ^ dneg;
    cell_o.dividend = nneg ? QuoWidth'(-numx) : QuoWidth'(numx);
    cell_o.divisor  = dneg ? RemWidth'(-$signed({den[VelWidth-1], den}))
                           : RemWidth'({1'b0, den});
    cell_o.rem      = '0;
    cell_o.quo      = '0;
  end

endmodule

// ----- hdl/sbc_div_cell.sv -----
module sbc_div_cell
  import sbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cell_t cell_i,
  output cell_t cell_o
);

  cell_t nxt_d, cell_q;
  logic  valid_q;
  logic [RemWidth:0] trial;

  always_comb begin
    nxt_d = cell_i;
    trial = {cell_i.rem, cell_i.dividend[QuoWidth-1]};
    nxt_d.dividend = {cell_i.dividend[QuoWidth-2:0], 1'b0};
    if (trial >= {1'b0, cell_i.divisor}) begin
      nxt_d.rem = RemWidth'(trial - {1'b0, cell_i.divisor});
      nxt_d.quo = {cell_i.quo[QuoWidth-2:0], 1'b1};
    end else begin
      nxt_d.rem = RemWidth'(trial);
      nxt_d.quo = {cell_i.quo[QuoWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= nxt_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= nxt_d;
    end
  end

  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule

// ----- hdl/swept_box_collision_unit.sv -----
// Swept AABB test: one box pair per cycle when the output is not stalled, fully
// pipelined. There are 44 register stages: one for edges and cross-product
// multiplies, 42 for a chain of restoring divider cells (one quotient bit each),
// then one output register; a request passes through them in that order.
// The whole pipe advances only when the output register is free or taken.
`include "swept_box_collision_unit_assert.svh"
module swept_box_collision_unit
  import sbc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  sbc_req_if.sink   req_i,
  sbc_rsp_if.source rsp_o
);

  localparam logic signed [QuoWidth:0] FracMax = (QuoWidth+1)'(8388607);
  localparam logic signed [QuoWidth:0] FracMin = -(QuoWidth+1)'(8388608);

  cell_t chain [DivCells+1];
  logic  en;
  logic  out_valid_q;
  rsp_t  rsp_q;

  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  sbc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .req_i   (req_i.req),
    .cell_o  (chain[0])
  );

  for (genvar g = 0; g < DivCells; g++) begin : g_cell
    sbc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  cell_t last;
  logic signed [QuoWidth:0] q;
  rsp_t rsp_d;

  always_comb begin
    last = chain[DivCells];
    q = last.neg ? -$signed({1'b0, last.quo}) : $signed({1'b0, last.quo});
    rsp_d.overlap  = last.overlap;
    rsp_d.hit_side = last.side;
    if (last.side == SIDE_NONE) begin
      rsp_d.contact_fraction   = FracWidth'(1 << OutFrac);
      rsp_d.fraction_saturated = 1'b0;
    end else if (q > FracMax) begin
      rsp_d.contact_fraction   = FracWidth'(FracMax);
      rsp_d.fraction_saturated = 1'b1;
    end else if (q < FracMin) begin
      rsp_d.contact_fraction   = FracWidth'(FracMin);
      rsp_d.fraction_saturated = 1'b1;
    end else begin
      rsp_d.contact_fraction   = FracWidth'(q);
      rsp_d.fraction_saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.rsp   = rsp_q;

  `SBC_ASSERT_IMP(a_stall_holds, clk_i, rst_ni, out_valid_q && !rsp_o.ready, !req_i.ready, "accepted while stalled")
  `SBC_ASSERT_IMP(a_none_unity, clk_i, rst_ni, out_valid_q && rsp_q.hit_side == SIDE_NONE, rsp_q.contact_fraction == FracWidth'(1 << OutFrac) && !rsp_q.fraction_saturated, "no side but fraction not one")
  `SBC_ASSERT_IMP(a_side_range, clk_i, rst_ni, out_valid_q, rsp_q.hit_side <= 3'(SIDE_NONE), "bad side code")
  `SBC_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_valid_q && !rsp_o.ready, out_valid_q && $stable(rsp_q), "result lost under stall")

endmodule

// ----- test/swept_box_collision_unit_tb.sv -----
module swept_box_collision_unit_tb;
  import sbc_pkg::*;

  localparam int MaxCycles = 400000;

  class collision_scoreboard;
    rsp_t expected_q[$];
    int   mismatches;
    int   results_seen;

    function automatic logic signed [63:0] sx(logic [63:0] v, int w);
      logic signed [63:0] r;
      r = v << (64 - w);
      return r >>> (64 - w);
    endfunction

    function automatic int cross_sign(logic signed [63:0] ax, logic signed [63:0] ay,
                                      logic signed [63:0] vx, logic signed [63:0] vy);
      logic signed [63:0] c;
      c = ax * vy - ay * vx;
      return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
    endfunction

    function automatic rsp_t predict_contact(req_t r);
      logic signed [63:0] sl, st, sw, sh, vx, vy, ol, ot, ow, oh;
      logic signed [63:0] sr, sb, orr, ob, ml, mt, num, den, q;
      side_e side;
      int c;
      rsp_t e;
      sl = sx(64'(r.self_left), CoordWidth);
      st = sx(64'(r.self_top), CoordWidth);
      sw = 64'(r.self_width) << FracBits;
      sh = 64'(r.self_height) << FracBits;
      vx = sx(64'(r.vel_x), VelWidth);
      vy = sx(64'(r.vel_y), VelWidth);
      ol = sx(64'(r.other_left), CoordWidth);
      ot = sx(64'(r.other_top), CoordWidth);
      ow = 64'(r.other_width) << FracBits;
      oh = 64'(r.other_height) << FracBits;
      sr = sl + sw; sb = st + sh; orr = ol + ow; ob = ot + oh;
      ml = sl + vx; mt = st + vy;
      e = '0;
      e.overlap = (ol < ml + sw) && (ml < orr) && (ot < mt + sh) && (mt < ob);
      if (vx > 0 && vy > 0)
        side = (cross_sign(ol - sr, ot - sb, vx, vy) < 0) ? SIDE_DOWN : SIDE_RIGHT;
      else if (vx < 0 && vy > 0)
        side = (cross_sign(orr - sl, ot - sb, vx, vy) < 0) ? SIDE_LEFT : SIDE_DOWN;
      else if (vx < 0 && vy < 0) begin
        c = cross_sign(orr - sl, ob - st, vx, vy);
        side = (c < 0) ? SIDE_UP : ((c == 0) ? SIDE_NONE : SIDE_LEFT);
      end else if (vx > 0 && vy < 0)
        side = (cross_sign(ol - sr, ob - st, vx, vy) <= 0) ? SIDE_RIGHT : SIDE_UP;
      else if (vx > 0) side = SIDE_RIGHT;
      else if (vy > 0) side = SIDE_DOWN;
      else if (vx < 0) side = SIDE_LEFT;
      else if (vy < 0) side = SIDE_UP;
      else side = SIDE_NONE;
      num = 0; den = 1;
      case (side)
        SIDE_RIGHT: begin num = ol - sr; den = vx; end
        SIDE_DOWN: begin num = ot - sb; den = vy; end
        SIDE_LEFT: begin num = orr - sl; den = vx; end
        SIDE_UP: begin num = ob - st; den = vy; end
        default: ;
      endcase
      e.hit_side = side;
      if (side == SIDE_NONE) begin
        q = 64'sd1 <<< OutFrac;
      end else begin
        q = (num * (64'sd1 <<< OutFrac)) / den;
        if (q > 64'sd8388607) begin q = 64'sd8388607; e.fraction_saturated = 1'b1; end
        if (q < -64'sd8388608) begin q = -64'sd8388608; e.fraction_saturated = 1'b1; end
      end
      e.contact_fraction = q[FracWidth-1:0];
      return e;
    endfunction

    function void note_request(req_t r);
      expected_q.push_back(predict_contact(r));
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.overlap !== e.overlap || got.hit_side !== e.hit_side ||
          got.contact_fraction !== e.contact_fraction ||
          got.fraction_saturated !== e.fraction_saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp ov=%b side=%0d frac=%h sat=%b, got ov=%b side=%0d frac=%h sat=%b",
                   results_seen, e.overlap, e.hit_side, e.contact_fraction,
                   e.fraction_saturated, got.overlap, got.hit_side, got.contact_fraction,
                   got.fraction_saturated);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  sbc_req_if req_if ();
  sbc_rsp_if rsp_if ();

  swept_box_collision_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  collision_scoreboard board = new();
  int  cycle_count = 0;
  int  requests_sent = 0;
  int  long_hold = 0;
  req_t directed_q[$];

  initial begin
    req_if.valid = 1'b0;
    req_if.req = '0;
    rsp_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) board.note_request(req_if.req);
    if (rst_ni && rsp_if.valid && rsp_if.ready) board.check_result(rsp_if.rsp);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) rsp_if.ready <= 1'b0;
    else if (long_hold > 0) begin
      rsp_if.ready <= 1'b0;
      long_hold <= long_hold - 1;
    end else if ((cycle_count / 200) % 3 == 0) rsp_if.ready <= 1'b1;
    else rsp_if.ready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [CoordWidth-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return CoordWidth'($urandom);
      1: return {1'b0, {(CoordWidth-1){1'b1}}};
      2: return {1'b1, {(CoordWidth-1){1'b0}}};
      default: return CoordWidth'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  function automatic logic [VelWidth-1:0] pick_vel();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return VelWidth'($urandom);
      2: return 16'h7fff;
      3: return 16'h8000;
      default: return VelWidth'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [SizeWidth-1:0] pick_size();
    return ($urandom_range(0, 3) == 0) ? SizeWidth'($urandom) : SizeWidth'($urandom_range(0, 64));
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.self_left = pick_coord();
    r.self_top = pick_coord();
    r.self_width = pick_size();
    r.self_height = pick_size();
    r.vel_x = pick_vel();
    r.vel_y = pick_vel();
    if ($urandom_range(0, 2) != 0) begin
      r.other_left = r.self_left + CoordWidth'($signed($urandom_range(0, 8000)) - 4000);
      r.other_top = r.self_top + CoordWidth'($signed($urandom_range(0, 8000)) - 4000);
    end else begin
      r.other_left = pick_coord();
      r.other_top = pick_coord();
    end
    r.other_width = pick_size();
    r.other_height = pick_size();
    return r;
  endfunction

  task automatic send_request(req_t r);
    req_if.valid <= 1'b1;
    req_if.req <= r;
    do @(posedge clk_i); while (!req_if.ready);
    requests_sent++;
  endtask

  task automatic pause_sender(int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic build_directed();
    req_t r;
    int vx[9] = '{0, 256, -256, 0, 0, 256, -256, -256, 256};
    int vy[9] = '{0, 0, 0, 256, -256, 256, 256, -256, -256};
    for (int k = 0; k < 9; k++) begin
      r = '0;
      r.self_width = 12'd4; r.self_height = 12'd4;
      r.other_left = 24'sd2048; r.other_top = 24'sd1536;
      r.other_width = 12'd8; r.other_height = 12'd8;
      r.vel_x = VelWidth'(vx[k]); r.vel_y = VelWidth'(vy[k]);
      directed_q.push_back(r);
    end
    r = '0;
    r.self_left = 24'sd2048; r.self_top = 24'sd2048;
    r.vel_x = -16'sd256; r.vel_y = -16'sd256;
    directed_q.push_back(r);
    r = '0;
    r.self_left = {1'b0, {23{1'b1}}}; r.self_top = {1'b0, {23{1'b1}}};
    r.self_width = '1; r.self_height = '1;
    r.other_left = {1'b1, 23'd0}; r.other_top = {1'b1, 23'd0};
    r.other_width = '1; r.other_height = '1;
    r.vel_x = 16'h8000; r.vel_y = 16'h7fff;
    directed_q.push_back(r);
    r.vel_x = 16'h0001; r.vel_y = 16'h0000;
    directed_q.push_back(r);
    r.vel_x = 16'h7fff; r.vel_y = 16'h8000;
    directed_q.push_back(r);
    r = '0;
    r.self_width = 12'd8; r.self_height = 12'd8;
    r.other_left = 24'sd1024; r.other_top = 24'sd1024;
    r.other_width = 12'd8; r.other_height = 12'd8;
    r.vel_x = 16'sd512; r.vel_y = 16'sd512;
    directed_q.push_back(r);
    r.vel_x = 16'sd1; r.vel_y = 16'sd0;
    directed_q.push_back(r);
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    build_directed();
    foreach (directed_q[k]) send_request(directed_q[k]);
    pause_sender(3);
    long_hold <= 150;
    for (int k = 0; k < 120; k++) send_request(random_request());
    pause_sender(1);
    while (board.expected_q.size() != 0) @(posedge clk_i);
    while (requests_sent < 540) begin
      n = $urandom_range(1, 30);
      for (int k = 0; k < n; k++) send_request(random_request());
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    req_if.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d box pairs: all hit sides, diagonal ties, saturated fractions",
             requests_sent);
    $display("output stalls, a long receiver hold and a full drain were exercised");
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
